### hdl/decimal_digits_with_leading_blanks_macros.svh
// assertion macros shared by the checker
`ifndef DECIMAL_DIGITS_WITH_LEADING_BLANKS_MACROS_SVH
`define DECIMAL_DIGITS_WITH_LEADING_BLANKS_MACROS_SVH

// same-cycle implication
`define DDLB_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define DDLB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/ddlb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ddlb_pkg;

    localparam int MAX_DIGITS_DEF = 10;
    localparam int VALUE_W        = 32;
    localparam int COUNT_W        = 4;
    localparam int START_COL_W    = 7;
    localparam int ROW_W          = 6;
    localparam int CODE_W         = 6;
    localparam int COLUMN_W       = 8;
    localparam int FONT_W         = 5;
    localparam int BIT_CNT_W      = $clog2(VALUE_W);

    localparam logic [FONT_W-1:0] FONT_HEIGHT_RESET = 5'd16;
    localparam logic [CODE_W-1:0] CHAR_SPACE        = 6'd32;
    localparam logic [CODE_W-1:0] CHAR_ZERO         = 6'd48;
    localparam logic [CODE_W-1:0] CHAR_NINE         = 6'd57;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_EMIT
    } state_t;

endpackage

`default_nettype wire

### hdl/decimal_digits_with_leading_blanks.sv
// channel    direction  ports                                         handshake
// command    in         start, value, digit_count, start_column, row  start && !busy
// result     out        char_code, column, out_row, last              strobe, one cycle
// config     in         cfg_data                                      cfg_valid && cfg_ready
//
// an item first runs bit-serial double dabble (one value bit per cycle),
// then emits one word per digit position
// a digit count of zero leaves the block idle with no word
// rst_n clears the controller and sets font height to 16
// results cannot be stalled; busy holds off new commands until the last word
`timescale 1ns / 1ps
`default_nettype none

module decimal_digits_with_leading_blanks #(
    parameter int MAX_DIGITS = ddlb_pkg::MAX_DIGITS_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire logic [ddlb_pkg::VALUE_W-1:0]       value,
    input  wire logic [ddlb_pkg::COUNT_W-1:0]       digit_count,
    input  wire logic [ddlb_pkg::START_COL_W-1:0]   start_column,
    input  wire logic [ddlb_pkg::ROW_W-1:0]         row,
    output logic                                    strobe,
    output logic [ddlb_pkg::CODE_W-1:0]             char_code,
    output logic [ddlb_pkg::COLUMN_W-1:0]           column,
    output logic [ddlb_pkg::ROW_W-1:0]              out_row,
    output logic                                    last,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [ddlb_pkg::FONT_W-1:0]        cfg_data
);

    localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam logic [ddlb_pkg::COUNT_W-1:0] MAX_CNT = ddlb_pkg::COUNT_W'(MAX_DIGITS);
    localparam logic [ddlb_pkg::BIT_CNT_W-1:0] LAST_BIT =
        ddlb_pkg::BIT_CNT_W'(ddlb_pkg::VALUE_W - 1);

    ddlb_pkg::state_t state_reg, state_next;

    logic [ddlb_pkg::BIT_CNT_W-1:0]  bit_cnt_reg, bit_cnt_next;
    logic [ddlb_pkg::VALUE_W-1:0]    value_reg, value_next;
    logic [MAX_DIGITS-1:0][3:0]      bcd_reg, bcd_next;
    logic [IDX_W-1:0]                idx_reg, idx_next;
    logic [ddlb_pkg::COLUMN_W-1:0]   col_reg, col_next;
    logic [ddlb_pkg::ROW_W-1:0]      row_reg, row_next;
    logic                            shown_reg, shown_next;
    logic [ddlb_pkg::FONT_W-1:0]     font_height_reg;

    logic                            accept;
    logic [ddlb_pkg::COUNT_W-1:0]    count_sat;
    logic [MAX_DIGITS-1:0][3:0]      bcd_adj;
    logic [MAX_DIGITS-1:0][3:0]      bcd_shift;
    logic [3:0]                      digit;
    logic                            blank;

    assign accept    = start && !busy;
    assign count_sat = (digit_count > MAX_CNT) ? MAX_CNT : digit_count;
    assign cfg_ready = 1'b1;

    // add-3 correction per digit, then shift the chain left by one bit
    always_comb
    begin
        for (int i = 0; i < MAX_DIGITS; i++)
        begin
            bcd_adj[i] = (bcd_reg[i] >= 4'd5) ? bcd_reg[i] + 4'd3 : bcd_reg[i];
        end
        bcd_shift[0] = {bcd_adj[0][2:0], value_reg[ddlb_pkg::VALUE_W-1]};
        for (int i = 1; i < MAX_DIGITS; i++)
        begin
            bcd_shift[i] = {bcd_adj[i][2:0], bcd_adj[i-1][3]};
        end
    end

    assign digit = bcd_reg[idx_reg];
    assign blank = !shown_reg && (idx_reg != '0) && (digit == 4'd0);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ddlb_pkg::ST_IDLE:
            begin
                if (accept && (count_sat != '0))
                begin
                    state_next = ddlb_pkg::ST_CONVERT;
                end
            end
            ddlb_pkg::ST_CONVERT:
            begin
                if (bit_cnt_reg == LAST_BIT)
                begin
                    state_next = ddlb_pkg::ST_EMIT;
                end
            end
            ddlb_pkg::ST_EMIT:
            begin
                if (idx_reg == '0)
                begin
                    state_next = ddlb_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ddlb_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        busy      = (state_reg != ddlb_pkg::ST_IDLE);
        strobe    = (state_reg == ddlb_pkg::ST_EMIT);
        last      = (idx_reg == '0);
        char_code = blank ? ddlb_pkg::CHAR_SPACE
                          : ddlb_pkg::CHAR_ZERO + ddlb_pkg::CODE_W'(digit);
        column    = col_reg;
        out_row   = row_reg;
    end

    // datapath
    always_comb
    begin
        bit_cnt_next = bit_cnt_reg;
        value_next   = value_reg;
        bcd_next     = bcd_reg;
        idx_next     = idx_reg;
        col_next     = col_reg;
        row_next     = row_reg;
        shown_next   = shown_reg;
        unique case (state_reg)
            ddlb_pkg::ST_IDLE:
            begin
                bit_cnt_next = '0;
                value_next   = value;
                bcd_next     = '0;
                idx_next     = IDX_W'(count_sat - 4'd1);
                col_next     = ddlb_pkg::COLUMN_W'(start_column);
                row_next     = row;
                shown_next   = 1'b0;
            end
            ddlb_pkg::ST_CONVERT:
            begin
                bit_cnt_next = bit_cnt_reg + ddlb_pkg::BIT_CNT_W'(1);
                value_next   = {value_reg[ddlb_pkg::VALUE_W-2:0], 1'b0};
                bcd_next     = bcd_shift;
            end
            ddlb_pkg::ST_EMIT:
            begin
                idx_next   = idx_reg - IDX_W'(1);
                col_next   = col_reg + ddlb_pkg::COLUMN_W'(font_height_reg[ddlb_pkg::FONT_W-1:1]);
                shown_next = shown_reg || !blank;
            end
            default:
            begin
                bit_cnt_next = bit_cnt_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ddlb_pkg::ST_IDLE;
            font_height_reg <= ddlb_pkg::FONT_HEIGHT_RESET;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                font_height_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        bit_cnt_reg <= bit_cnt_next;
        value_reg   <= value_next;
        bcd_reg     <= bcd_next;
        idx_reg     <= idx_next;
        col_reg     <= col_next;
        row_reg     <= row_next;
        shown_reg   <= shown_next;
    end

endmodule

`default_nettype wire

### hdl/ddlb_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "decimal_digits_with_leading_blanks_macros.svh"

module ddlb_checker (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           start,
    input wire logic                           busy,
    input wire logic [ddlb_pkg::COUNT_W-1:0]   digit_count,
    input wire logic                           strobe,
    input wire logic [ddlb_pkg::CODE_W-1:0]    char_code,
    input wire logic                           last
);

    // words only come out while a command is in progress
    `DDLB_ASSERT_NOW(a_strobe_busy, strobe, busy, "result word while not busy")

    // digits of one number follow each other without a gap
    `DDLB_ASSERT_NEXT(a_no_gap, strobe && !last, strobe, "gap inside a number")

    // the final position always shows a digit
    `DDLB_ASSERT_NOW(a_last_digit, strobe && last, char_code != ddlb_pkg::CHAR_SPACE,
        "final position blanked")

    // once a digit is shown no later position is blanked
    `DDLB_ASSERT_NEXT(a_no_late_blank, strobe && !last && char_code != ddlb_pkg::CHAR_SPACE,
        char_code != ddlb_pkg::CHAR_SPACE, "blank after a shown digit")

    // a command with digits to show makes the block busy
    `DDLB_ASSERT_NEXT(a_start_busy, start && !busy && digit_count != '0, busy,
        "command with digits not taken up")

endmodule

bind decimal_digits_with_leading_blanks ddlb_checker u_ddlb_checker (.*);

`default_nettype wire
